>>> src/hcbd_pkg.sv
// ============================================================================
// hcbd_pkg
// Shared types, constants and a helper function of the chunked body decoder.
// ============================================================================
`default_nettype none

package hcbd_pkg;

    // Width of the chunk size and the data byte counter.
    localparam int SIZE_BITS = 31;

    // Result status codes.
    localparam logic [1:0] ST_PAYLOAD = 2'd0;
    localparam logic [1:0] ST_END     = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    // Characters that the parser looks for.
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Decoder phases.
    typedef enum logic [2:0] {
        PH_DIGITS = 3'd0,
        PH_EXT    = 3'd1,
        PH_CR     = 3'd2,
        PH_DATA   = 3'd3,
        PH_SKIP1  = 3'd4,
        PH_SKIP2  = 3'd5,
        PH_DONE   = 3'd6,
        PH_ERROR  = 3'd7
    } phase_t;

    // Result of decoding one character as a hex digit.
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    // Decodes one ASCII character as a hex digit of either case.
    function automatic hex_digit_t hex_decode(input logic [7:0] ch);
        hex_digit_t res;
        res.valid = 1'b1;
        res.value = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            res.value = 4'(ch - 8'h30);
        end
        else if (ch >= 8'h61 && ch <= 8'h66)
        begin
            res.value = 4'(ch - 8'h57);
        end
        else if (ch >= 8'h41 && ch <= 8'h46)
        begin
            res.value = 4'(ch - 8'h37);
        end
        else
        begin
            res.valid = 1'b0;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> src/http_chunked_body_decoder_top.sv
// ============================================================================
// http_chunked_body_decoder_top
// Chunked HTTP body decoder: passes on payload bytes and flags end or error.
// ============================================================================
//
// Channel  Dir  Handshake           tdata      tuser
// s_*      in   s_tvalid/s_tready   in_byte    new_body
// m_*      out  m_tvalid/m_tready   out_byte   status
//
// One item per cycle sustained while the output is not stalled; a result is
// presented after its item has passed the input register, then the result register.
// The per-byte state update is a single shift-add of one hex digit or a
// decrement of the byte counter, done between the two registers.
// Reset clears the phase, the counter, the digit flag and both valid bits.
// A stalled output holds the result register; the input register keeps
// accepting while it is empty or while its item moves on in that cycle.
//
`default_nettype none

module http_chunked_body_decoder_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic [0:0] s_tuser,   // [0] new_body
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic [1:0]      m_tuser    // [1:0] status
);

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_new_reg;

    // Decoder state.
    hcbd_pkg::phase_t                 phase_reg, phase_next;
    logic [hcbd_pkg::SIZE_BITS-1:0]   count_reg, count_next;
    logic                             seen_reg, seen_next;

    // Result register.
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic [1:0] out_status_reg;

    // Result computed for the item in the input register.
    logic       res_valid;
    logic [7:0] res_byte;
    logic [1:0] res_status;

    logic advance;
    hcbd_pkg::phase_t               ph_eff;
    logic [hcbd_pkg::SIZE_BITS-1:0] cnt_eff;
    logic [hcbd_pkg::SIZE_BITS-1:0] cnt_dec;
    logic                           seen_eff;
    hcbd_pkg::hex_digit_t           digit;

    // The held item moves on when the result register is free or drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // A new body restarts the size line with this byte.
    assign ph_eff   = in_new_reg ? hcbd_pkg::PH_DIGITS : phase_reg;
    assign cnt_eff  = in_new_reg ? '0 : count_reg;
    assign seen_eff = in_new_reg ? 1'b0 : seen_reg;
    assign digit    = hcbd_pkg::hex_decode(in_byte_reg);
    assign cnt_dec  = cnt_eff - hcbd_pkg::SIZE_BITS'(1);

    // Next-state logic.
    always_comb
    begin
        phase_next = ph_eff;
        count_next = cnt_eff;
        seen_next  = seen_eff;
        case (ph_eff)
            hcbd_pkg::PH_DIGITS:
            begin
                if (digit.valid)
                begin
                    if (cnt_eff[hcbd_pkg::SIZE_BITS-1 -: 4] != 4'd0)
                    begin
                        phase_next = hcbd_pkg::PH_ERROR;
                        count_next = '0;
                        seen_next  = 1'b0;
                    end
                    else
                    begin
                        count_next = {cnt_eff[hcbd_pkg::SIZE_BITS-5:0], digit.value};
                        seen_next  = 1'b1;
                    end
                end
                else if (!seen_eff)
                begin
                    phase_next = hcbd_pkg::PH_ERROR;
                    count_next = '0;
                    seen_next  = 1'b0;
                end
                else if (in_byte_reg == hcbd_pkg::CHAR_CR)
                begin
                    phase_next = hcbd_pkg::PH_CR;
                end
                else
                begin
                    phase_next = hcbd_pkg::PH_EXT;
                end
            end
            hcbd_pkg::PH_EXT:
            begin
                if (in_byte_reg == hcbd_pkg::CHAR_CR)
                begin
                    phase_next = hcbd_pkg::PH_CR;
                end
            end
            hcbd_pkg::PH_CR:
            begin
                if (in_byte_reg == hcbd_pkg::CHAR_LF)
                begin
                    phase_next = (cnt_eff == '0) ? hcbd_pkg::PH_DONE : hcbd_pkg::PH_DATA;
                end
                else if (in_byte_reg != hcbd_pkg::CHAR_CR)
                begin
                    phase_next = hcbd_pkg::PH_EXT;
                end
            end
            hcbd_pkg::PH_DATA:
            begin
                count_next = cnt_dec;
                if (cnt_dec == '0)
                begin
                    phase_next = hcbd_pkg::PH_SKIP1;
                end
            end
            hcbd_pkg::PH_SKIP1:
            begin
                phase_next = hcbd_pkg::PH_SKIP2;
            end
            hcbd_pkg::PH_SKIP2:
            begin
                phase_next = hcbd_pkg::PH_DIGITS;
                count_next = '0;
                seen_next  = 1'b0;
            end
            default:
            begin
                phase_next = ph_eff;
            end
        endcase
    end

    // Result logic.
    always_comb
    begin
        res_valid  = 1'b0;
        res_byte   = 8'd0;
        res_status = hcbd_pkg::ST_PAYLOAD;
        case (ph_eff)
            hcbd_pkg::PH_DIGITS:
            begin
                if ((digit.valid && cnt_eff[hcbd_pkg::SIZE_BITS-1 -: 4] != 4'd0) ||
                    (!digit.valid && !seen_eff))
                begin
                    res_valid  = 1'b1;
                    res_status = hcbd_pkg::ST_ERROR;
                end
            end
            hcbd_pkg::PH_CR:
            begin
                if (in_byte_reg == hcbd_pkg::CHAR_LF && cnt_eff == '0)
                begin
                    res_valid  = 1'b1;
                    res_status = hcbd_pkg::ST_END;
                end
            end
            hcbd_pkg::PH_DATA:
            begin
                res_valid = 1'b1;
                res_byte  = in_byte_reg;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= hcbd_pkg::PH_DIGITS;
            count_reg     <= '0;
            seen_reg      <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                phase_reg     <= phase_next;
                count_reg     <= count_next;
                seen_reg      <= seen_next;
                out_valid_reg <= res_valid;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_new_reg  <= s_tuser[0];
        end
        if (advance && res_valid)
        begin
            out_byte_reg   <= res_byte;
            out_status_reg <= res_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_status_reg;

`ifndef SYNTHESIS
    // End and error results carry a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != hcbd_pkg::ST_PAYLOAD) |-> (m_tdata == 8'd0))
        else $error("non-payload result with nonzero byte");

    // The status code is always one of the three defined codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == hcbd_pkg::ST_PAYLOAD || m_tuser == hcbd_pkg::ST_END ||
                      m_tuser == hcbd_pkg::ST_ERROR))
        else $error("undefined status code");

    // While data bytes are pending the counter never reads zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == hcbd_pkg::PH_DATA) |-> (count_reg != '0))
        else $error("data phase with zero byte count");

    // Done and error phases drop bytes until a new body starts.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_new_reg &&
         (phase_reg == hcbd_pkg::PH_DONE || phase_reg == hcbd_pkg::PH_ERROR))
        |=> !m_tvalid)
        else $error("result produced after end of body or error");
`endif

endmodule

`default_nettype wire

>>> tb/http_chunked_body_decoder_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// http_chunked_body_decoder_top_tb
// Self-checking testbench of the chunked HTTP body decoder.
// A queue of raw body bytes is built up front: a short directed body set,
// then random well-formed bodies mixed with malformed and oversized ones.
// A clocked driver offers the bytes with random gaps. A clocked monitor
// takes results with random stalls and one long hold-off. Each result is
// checked against a decoder model that runs on every accepted byte.
// ============================================================================

module http_chunked_body_decoder_top_tb;

    localparam int LIMIT_CYCLES = 400000;
    localparam int TARGET_ITEMS = 1150;
    localparam int TAIL_ITEMS   = 150;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [7:0] data;
        logic       new_body;
    } body_byte_t;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] status;
    } decoded_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] in_byte
    logic [0:0] s_tuser = 1'b0;    // [0] new_body
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] out_byte
    logic [1:0] m_tuser;           // [1:0] status

    body_byte_t pending_bytes[$];
    decoded_t   expected_out[$];
    int         stim_items = 0;
    int         error_cnt = 0;
    int         result_cnt = 0;
    int         cycle_cnt = 0;
    logic       quiet_tail = 1'b0;

    // Decoder model state.
    hcbd_pkg::phase_t               dec_phase = hcbd_pkg::PH_DIGITS;
    logic [hcbd_pkg::SIZE_BITS-1:0] dec_count = '0;
    logic                           dec_digit_seen = 1'b0;

    // Sender and receiver pacing.
    int   tx_gap = 0;
    int   tx_rate = 0;
    int   rx_gap = 0;
    int   rx_rate = 0;
    int   rx_hold = 0;
    int   rx_cyc = 0;
    logic long_hold_done = 1'b0;

    http_chunked_body_decoder_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // Value of an ASCII hex digit, or -1 for any other byte.
    function automatic int hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return int'(c) - int'("0");
        end
        if (c >= "a" && c <= "f")
        begin
            return int'(c) - int'("a") + 10;
        end
        if (c >= "A" && c <= "F")
        begin
            return int'(c) - int'("A") + 10;
        end
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 10)
        begin
            return 8'(int'("0") + v);
        end
        return upper ? 8'(int'("A") + v - 10) : 8'(int'("a") + v - 10);
    endfunction

    task automatic flag_error(input string msg);
        $display("mismatch: %s", msg);
        error_cnt++;
    endtask

    // Runs one accepted byte through the decoder model and queues its result.
    task automatic decode_byte(input logic [7:0] b, input logic nb);
        int d;
        d = hex_value(b);
        if (nb)
        begin
            dec_phase = hcbd_pkg::PH_DIGITS;
            dec_count = '0;
            dec_digit_seen = 1'b0;
        end
        case (dec_phase)
            hcbd_pkg::PH_DIGITS:
            begin
                // A missing digit or a size that would not fit is an error.
                if ((d < 0 && !dec_digit_seen) ||
                    (d >= 0 && dec_count[hcbd_pkg::SIZE_BITS-1 -: 4] != 4'd0))
                begin
                    dec_phase = hcbd_pkg::PH_ERROR;
                    dec_count = '0;
                    dec_digit_seen = 1'b0;
                    expected_out.push_back('{data: 8'h00, status: hcbd_pkg::ST_ERROR});
                end
                else if (d >= 0)
                begin
                    dec_count = {dec_count[hcbd_pkg::SIZE_BITS-5:0], 4'(d)};
                    dec_digit_seen = 1'b1;
                end
                else
                begin
                    dec_phase = (b == hcbd_pkg::CHAR_CR) ? hcbd_pkg::PH_CR : hcbd_pkg::PH_EXT;
                end
            end
            hcbd_pkg::PH_EXT:
            begin
                if (b == hcbd_pkg::CHAR_CR)
                begin
                    dec_phase = hcbd_pkg::PH_CR;
                end
            end
            hcbd_pkg::PH_CR:
            begin
                if (b == hcbd_pkg::CHAR_LF)
                begin
                    if (dec_count == '0)
                    begin
                        dec_phase = hcbd_pkg::PH_DONE;
                        expected_out.push_back('{data: 8'h00, status: hcbd_pkg::ST_END});
                    end
                    else
                    begin
                        dec_phase = hcbd_pkg::PH_DATA;
                    end
                end
                else if (b != hcbd_pkg::CHAR_CR)
                begin
                    dec_phase = hcbd_pkg::PH_EXT;
                end
            end
            hcbd_pkg::PH_DATA:
            begin
                dec_count = dec_count - 1'b1;
                if (dec_count == '0)
                begin
                    dec_phase = hcbd_pkg::PH_SKIP1;
                end
                expected_out.push_back('{data: b, status: hcbd_pkg::ST_PAYLOAD});
            end
            hcbd_pkg::PH_SKIP1:
            begin
                dec_phase = hcbd_pkg::PH_SKIP2;
            end
            hcbd_pkg::PH_SKIP2:
            begin
                dec_phase = hcbd_pkg::PH_DIGITS;
                dec_count = '0;
                dec_digit_seen = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    // Bytes that take part in decoding count toward the stimulus total.
    task automatic push_byte(input logic [7:0] b, input logic nb);
        pending_bytes.push_back('{data: b, new_body: nb});
        stim_items++;
    endtask

    // Bytes that the decoder drops in the done or error phase.
    task automatic push_dropped(input int n);
        for (int i = 0; i < n; i++)
        begin
            pending_bytes.push_back('{data: 8'($urandom_range(0, 255)), new_body: 1'b0});
        end
    endtask

    task automatic push_text(input string s, input logic nb_first);
        for (int i = 0; i < s.len(); i++)
        begin
            push_byte(s[i], (i == 0) ? nb_first : 1'b0);
        end
    endtask

    // Size digits with optional leading zeros and random letter case.
    task automatic push_size(input logic [hcbd_pkg::SIZE_BITS-1:0] v, input logic nb_first);
        logic [31:0] w;
        int          n;
        int          zeros;
        logic        nb;
        w = 32'(v);
        n = 1;
        nb = nb_first;
        for (int i = 1; i < 8; i++)
        begin
            if ((w >> (4 * i)) != 0)
            begin
                n = i + 1;
            end
        end
        zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        for (int i = 0; i < zeros; i++)
        begin
            push_byte("0", nb);
            nb = 1'b0;
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            push_byte(hex_char(w[4 * i +: 4], 1'($urandom_range(0, 1))), nb);
            nb = 1'b0;
        end
    endtask

    // End of a size line: plain, with an extension, with a lone CR or CR CR.
    task automatic push_line_end();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0:
            begin
                push_byte(";", 1'b0);
                repeat ($urandom_range(1, 5))
                begin
                    do b = 8'($urandom_range(0, 255)); while (b == hcbd_pkg::CHAR_CR);
                    push_byte(b, 1'b0);
                end
            end
            1:
            begin
                push_byte(hcbd_pkg::CHAR_CR, 1'b0);
                do b = 8'($urandom_range(0, 255));
                while (b == hcbd_pkg::CHAR_CR || b == hcbd_pkg::CHAR_LF);
                push_byte(b, 1'b0);
            end
            2:
            begin
                push_byte(hcbd_pkg::CHAR_CR, 1'b0);
            end
            default:
            begin
            end
        endcase
        push_byte(hcbd_pkg::CHAR_CR, 1'b0);
        push_byte(hcbd_pkg::CHAR_LF, 1'b0);
    endtask

    // A complete chunked body, or, when cut is set, one that may be cut short inside its data.
    task automatic push_body(input bit cut);
        int n_chunks;
        int size;
        n_chunks = $urandom_range(1, 4);
        for (int c = 0; c < n_chunks; c++)
        begin
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
            push_size(hcbd_pkg::SIZE_BITS'(size), c == 0);
            push_line_end();
            for (int i = 0; i < size; i++)
            begin
                if (cut && $urandom_range(0, 15) == 0)
                begin
                    return;
                end
                push_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            if ($urandom_range(0, 3) == 0)
            begin
                push_byte(8'($urandom_range(0, 255)), 1'b0);
                push_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            else
            begin
                push_byte(hcbd_pkg::CHAR_CR, 1'b0);
                push_byte(hcbd_pkg::CHAR_LF, 1'b0);
            end
        end
        // Last chunk, sometimes written with a hex prefix that ends the digits.
        push_size('0, 1'b0);
        if ($urandom_range(0, 7) == 0)
        begin
            push_byte("x", 1'b0);
        end
        push_line_end();
        push_dropped($urandom_range(0, 3));
    endtask

    // Stimulus, reset and end of run.
    initial
    begin
        logic [7:0]                     b;
        logic [hcbd_pkg::SIZE_BITS-1:0] big;
        int                             pick;

        // Directed: lone CR, CR CR, ignored extension digits, both byte
        // extremes, unchecked trailer, hex prefix, done and error drops.
        push_text("2;F", 1'b1);
        push_byte(hcbd_pkg::CHAR_CR, 1'b0);
        push_byte("Z", 1'b0);
        push_byte(hcbd_pkg::CHAR_CR, 1'b0);
        push_byte(hcbd_pkg::CHAR_CR, 1'b0);
        push_byte(hcbd_pkg::CHAR_LF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_text("ab0x", 1'b0);
        push_byte(hcbd_pkg::CHAR_CR, 1'b0);
        push_byte(hcbd_pkg::CHAR_LF, 1'b0);
        push_dropped(1);
        push_byte(" ", 1'b1);
        push_dropped(1);
        push_text("80000000", 1'b1);

        // Random bodies, mostly well formed.
        while (stim_items < TARGET_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 78)
            begin
                push_body(pick < 10);
            end
            else if (pick < 88)
            begin
                do b = 8'($urandom_range(0, 255)); while (hex_value(b) >= 0);
                push_byte(b, 1'b1);
                push_dropped($urandom_range(0, 3));
            end
            else if (pick < 95)
            begin
                // Too many digits: the error comes at the eighth or ninth one.
                push_byte(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(0, 1))), 1'b1);
                repeat (8)
                begin
                    push_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))),
                              1'b0);
                end
                push_dropped($urandom_range(0, 2));
            end
            else
            begin
                // Very large chunk, cut off after a few data bytes.
                big = ($urandom_range(0, 1) == 1) ? '1 :
                      hcbd_pkg::SIZE_BITS'($urandom_range(32'h0800_0000, 32'h7FFF_FFFF));
                push_size(big, 1'b1);
                push_line_end();
                repeat ($urandom_range(1, 6))
                begin
                    push_byte(8'($urandom_range(0, 255)), 1'b0);
                end
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        while (expected_out.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_cnt == 0)
        begin
            $display("[http_chunked_body_decoder_top] OK");
        end
        else
        begin
            $display("[http_chunked_body_decoder_top] ERROR");
        end
        $finish;
    end

    // Driver: offers queued items, predicts each accepted one, idles in bursts.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                decode_byte(s_tdata, s_tuser[0]);
                void'(pending_bytes.pop_front());
            end
            quiet_tail <= (pending_bytes.size() < TAIL_ITEMS);
            if (cycle_cnt % 256 == 0)
            begin
                tx_rate = $urandom_range(0, 3);
            end
            // An offered item stays on the bus until it is taken.
            if (!(s_tvalid && !s_tready))
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                end
                else if (!quiet_tail && $urandom_range(0, 15) < tx_rate)
                begin
                    tx_gap = $urandom_range(1, 14);
                end
                if (tx_gap == 0 && pending_bytes.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_bytes[0].data;
                    s_tuser  <= pending_bytes[0].new_body;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall bursts and one long hold-off while items keep coming.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rx_cyc++;
            if (rx_cyc % 256 == 0)
            begin
                rx_rate = $urandom_range(0, 3);
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
            end
            else if (!long_hold_done && rx_cyc >= 600 && s_tvalid)
            begin
                rx_hold = HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
            end
            else if (!quiet_tail && $urandom_range(0, 15) < rx_rate)
            begin
                rx_gap = $urandom_range(1, 14);
            end
            m_tready <= (rx_hold == 0 && rx_gap == 0);
        end
    end

    // Monitor: each accepted result against the oldest expected one.
    always @(posedge clk)
    begin
        decoded_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_out.size() == 0)
            begin
                flag_error($sformatf("unexpected result byte %02h status %0d",
                                     m_tdata, m_tuser));
            end
            else
            begin
                want = expected_out.pop_front();
                if (m_tdata !== want.data)
                begin
                    flag_error($sformatf("result %0d out_byte %02h, want %02h",
                                         result_cnt, m_tdata, want.data));
                end
                if (m_tuser !== want.status)
                begin
                    flag_error($sformatf("result %0d status %0d, want %0d",
                                         result_cnt, m_tuser, want.status));
                end
            end
            result_cnt++;
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("[http_chunked_body_decoder_top] ERROR");
            $finish;
        end
    end

endmodule
